[rtl/core/ssos_pkg.sv]
// ssos_pkg: widths, constants, types and the triangle index function
// shared by the spatial sign outer sum core and its submodules
// depends on nothing
`default_nettype none

package ssos_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int COUNT_BITS      = 16;
   localparam int COORD_BITS      = 16;

   localparam int NUM_COORD_FIELDS = 4;
   localparam int CFG_BITS        = 3;
   localparam int FRAC_BITS       = 16;
   localparam int ACC_BITS        = 48;
   localparam int ENT_BITS        = 34;
   localparam int ROW_BITS        = 2;
   localparam int SKIP_BITS       = 16;
   localparam int SKIP_MAX        = (1 << SKIP_BITS) - 1;

   localparam int TRI_SIZE        = MAX_DIMS * (MAX_DIMS + 1) / 2;
   localparam int DIM_BITS        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int K_BITS          = $clog2(MAX_DIMS + 1);
   localparam int TRI_BITS        = (TRI_SIZE > 1) ? $clog2(TRI_SIZE) : 1;
   localparam int PROD_BITS       = 2 * COORD_BITS;
   localparam int SUM_BITS        = PROD_BITS + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
   localparam int Q_BITS          = FRAC_BITS + 1;
   localparam int STEP_BITS       = $clog2(Q_BITS);

   localparam logic [CFG_BITS-1:0] DIMS_RESET = CFG_BITS'(4);

   localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ENT_HI =
      {{(ACC_BITS-ENT_BITS+1){1'b0}}, {(ENT_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ENT_LO =
      {{(ACC_BITS-ENT_BITS+1){1'b1}}, {(ENT_BITS-1){1'b0}}};

   typedef struct packed {
      logic                write;
      logic                clear;
      logic [TRI_BITS-1:0] idx;
      logic [ACC_BITS-1:0] addend;
   } acc_cmd_type;

   // packed upper-triangle position of entry (i, j), symmetric
   function automatic logic [TRI_BITS-1:0] tri_index(input logic [DIM_BITS-1:0] i,
                                                    input logic [DIM_BITS-1:0] j);
      int a;
      int b;
      int r;
      a = (i < j) ? int'(i) : int'(j);
      b = (i < j) ? int'(j) : int'(i);
      r = a * MAX_DIMS - (a * (a - 1)) / 2 + (b - a);
      return TRI_BITS'(r);
   endfunction

endpackage

`default_nettype wire

[rtl/core/ssos_if.sv]
// ssos_if: valid/ready channel interfaces for request, response and csr write
// depends on ssos_pkg
`default_nettype none

interface ssos_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [ssos_pkg::COORD_BITS-1:0] coord_0;
   logic signed [ssos_pkg::COORD_BITS-1:0] coord_1;
   logic signed [ssos_pkg::COORD_BITS-1:0] coord_2;
   logic signed [ssos_pkg::COORD_BITS-1:0] coord_3;
   logic                         last_point;

   modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_point,
                   input ready);
   modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, last_point,
                   output ready);
endinterface

interface ssos_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ssos_pkg::ROW_BITS-1:0]        row;
   logic [ssos_pkg::ROW_BITS-1:0]        col;
   logic signed [ssos_pkg::ENT_BITS-1:0] entry;
   logic [ssos_pkg::SKIP_BITS-1:0]       skipped_points;
   logic                                 last_entry;

   modport source (output valid, row, col, entry, skipped_points, last_entry,
                   input ready);
   modport sink   (input valid, row, col, entry, skipped_points, last_entry,
                   output ready);
endinterface

interface ssos_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ssos_pkg::CFG_BITS-1:0] dims_in_use;

   modport source (output valid, dims_in_use, input ready);
   modport sink   (input valid, dims_in_use, output ready);
endinterface

`default_nettype wire

[rtl/core/spatial_sign_outer_sum_core.sv]
// spatial_sign_outer_sum_core: top level, sequencer around one multiplier,
// the shared divider ssos_div and the accumulator bank ssos_acc
// depends on ssos_pkg, ssos_if, ssos_div, ssos_acc
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    coord_0..coord_3, last_point
//   rsp_chan  out  valid/ready    row, col, entry, skipped_points, last_entry
//   csr_chan  in   valid/ready    dims_in_use (ready whenever out of reset)
//
// a point squares and sums its k coordinates, then divides each upper-triangle product by
// that sum in the shared divider, one quotient after another; a zero point is only counted
// a last point then emits k*k entries, one per cycle while rsp_chan is ready
// req_chan is ready only when idle; a stalled response holds the emit sequence
// reset is synchronous and clears the accumulators, the zero count and dims to 4
`default_nettype none

module spatial_sign_outer_sum_core (
   input  logic       clock,
   input  logic       reset,
   ssos_req_if.sink   req_chan,
   ssos_rsp_if.source rsp_chan,
   ssos_csr_if.sink   csr_chan
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_LOAD,
      ST_SQ_MUL,
      ST_SQ_ADD,
      ST_NORM,
      ST_PR_LOAD,
      ST_PR_MUL,
      ST_PR_START,
      ST_PR_WAIT,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   logic [ssos_pkg::CFG_BITS-1:0]          dims_ff, dims_in;
   logic [ssos_pkg::K_BITS-1:0]            k_ff, k_in;
   logic [ssos_pkg::DIM_BITS-1:0]          i_ff, i_in;
   logic [ssos_pkg::DIM_BITS-1:0]          j_ff, j_in;
   logic [ssos_pkg::COORD_BITS-1:0]        mag_ff [ssos_pkg::MAX_DIMS];
   logic [ssos_pkg::COORD_BITS-1:0]        mag_in [ssos_pkg::MAX_DIMS];
   logic [ssos_pkg::MAX_DIMS-1:0]          neg_ff, neg_in;
   logic                                   last_ff, last_in;
   logic [ssos_pkg::COORD_BITS-1:0]        opa_ff, opa_in;
   logic                                   nega_ff, nega_in;
   logic [ssos_pkg::PROD_BITS-1:0]         prod_ff, prod_in;
   logic [ssos_pkg::SUM_BITS-1:0]          sum_ff, sum_in;
   logic [ssos_pkg::COUNT_BITS-1:0]        cnt_ff, cnt_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [ssos_pkg::ROW_BITS-1:0]          rsp_row_ff, rsp_row_in;
   logic [ssos_pkg::ROW_BITS-1:0]          rsp_col_ff, rsp_col_in;
   logic [ssos_pkg::ENT_BITS-1:0]          rsp_entry_ff, rsp_entry_in;
   logic [ssos_pkg::SKIP_BITS-1:0]         rsp_skip_ff, rsp_skip_in;
   logic                                   rsp_last_ff, rsp_last_in;

   logic [ssos_pkg::COORD_BITS-1:0]        field_v [ssos_pkg::NUM_COORD_FIELDS];
   logic [ssos_pkg::COORD_BITS-1:0]        coord_v;
   logic [ssos_pkg::DIM_BITS-1:0]          rd_idx;
   logic [ssos_pkg::COORD_BITS-1:0]        mag_rd;
   logic                                   neg_rd;
   logic                                   i_last, j_last;
   logic                                   req_fire, out_free, final_load;
   logic                                   div_start, div_done;
   logic [ssos_pkg::Q_BITS-1:0]            div_quotient;
   logic [ssos_pkg::ACC_BITS-1:0]          q_ext;
   logic signed [ssos_pkg::ACC_BITS-1:0]   acc_rd;
   logic signed [ssos_pkg::ACC_BITS-1:0]   ent_sat;
   ssos_pkg::acc_cmd_type                  acc_cmd;

   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_chan.ready = !reset;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign field_v[0] = req_chan.coord_0;
   assign field_v[1] = req_chan.coord_1;
   assign field_v[2] = req_chan.coord_2;
   assign field_v[3] = req_chan.coord_3;

   assign rd_idx = (state_ff == ST_SQ_LOAD || state_ff == ST_PR_LOAD) ? i_ff : j_ff;
   assign mag_rd = mag_ff[rd_idx];
   assign neg_rd = neg_ff[rd_idx];
   assign i_last = (32'(i_ff) + 32'd1 == 32'(k_ff));
   assign j_last = (32'(j_ff) + 32'd1 == 32'(k_ff));
   assign final_load = (state_ff == ST_EMIT) && out_free && i_last && j_last;
   assign div_start  = (state_ff == ST_PR_START);
   assign q_ext      = ssos_pkg::ACC_BITS'(div_quotient);

   always_comb begin
      acc_cmd.write  = (state_ff == ST_PR_WAIT) && div_done;
      acc_cmd.clear  = final_load;
      acc_cmd.idx    = ssos_pkg::tri_index(i_ff, j_ff);
      acc_cmd.addend = (nega_ff ^ neg_rd) ? (~q_ext + 1'b1) : q_ext;
   end

   always_comb begin
      if (acc_rd > ssos_pkg::ENT_HI) begin
         ent_sat = ssos_pkg::ENT_HI;
      end else if (acc_rd < ssos_pkg::ENT_LO) begin
         ent_sat = ssos_pkg::ENT_LO;
      end else begin
         ent_sat = acc_rd;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dims_in      = dims_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      opa_in       = opa_ff;
      nega_in      = nega_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_skip_in  = rsp_skip_ff;
      rsp_last_in  = rsp_last_ff;
      coord_v      = '0;

      if (csr_chan.valid) begin
         dims_in = csr_chan.dims_in_use;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int d = 0; d < ssos_pkg::MAX_DIMS; d++) begin
                  if (d < ssos_pkg::NUM_COORD_FIELDS) begin
                     coord_v = field_v[d % ssos_pkg::NUM_COORD_FIELDS];
                  end else begin
                     coord_v = '0;
                  end
                  neg_in[d] = coord_v[ssos_pkg::COORD_BITS-1];
                  mag_in[d] = neg_in[d] ? (~coord_v + 1'b1) : coord_v;
               end
               if (dims_ff == '0) begin
                  k_in = ssos_pkg::K_BITS'(1);
               end else if (32'(dims_ff) > 32'(ssos_pkg::MAX_DIMS)) begin
                  k_in = ssos_pkg::K_BITS'(ssos_pkg::MAX_DIMS);
               end else begin
                  k_in = ssos_pkg::K_BITS'(dims_ff);
               end
               last_in  = req_chan.last_point;
               i_in     = '0;
               j_in     = '0;
               sum_in   = '0;
               state_in = ST_SQ_LOAD;
            end
         end
         ST_SQ_LOAD: begin
            opa_in   = mag_rd;
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            prod_in  = opa_ff * mag_rd;
            state_in = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            sum_in = sum_ff + ssos_pkg::SUM_BITS'(prod_ff);
            if (i_last) begin
               state_in = ST_NORM;
            end else begin
               i_in     = i_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = ST_SQ_LOAD;
            end
         end
         ST_NORM: begin
            i_in = '0;
            j_in = '0;
            if (sum_ff == '0) begin
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PR_LOAD;
            end
         end
         ST_PR_LOAD: begin
            opa_in   = mag_rd;
            nega_in  = neg_rd;
            state_in = ST_PR_MUL;
         end
         ST_PR_MUL: begin
            prod_in  = opa_ff * mag_rd;
            state_in = ST_PR_START;
         end
         ST_PR_START: begin
            state_in = ST_PR_WAIT;
         end
         ST_PR_WAIT: begin
            if (div_done) begin
               if (!j_last) begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PR_MUL;
               end else if (i_last) begin
                  state_in = ST_FINISH;
               end else begin
                  i_in     = i_ff + 1'b1;
                  j_in     = i_ff + 1'b1;
                  state_in = ST_PR_LOAD;
               end
            end
         end
         ST_FINISH: begin
            i_in     = '0;
            j_in     = '0;
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ssos_pkg::ROW_BITS'(i_ff);
               rsp_col_in   = ssos_pkg::ROW_BITS'(j_ff);
               rsp_entry_in = ent_sat[ssos_pkg::ENT_BITS-1:0];
               rsp_skip_in  = (32'(cnt_ff) > 32'(ssos_pkg::SKIP_MAX)) ?
                              '1 : ssos_pkg::SKIP_BITS'(cnt_ff);
               rsp_last_in  = i_last && j_last;
               if (!j_last) begin
                  j_in = j_ff + 1'b1;
               end else if (!i_last) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= ssos_pkg::DIMS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dims_ff      <= dims_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      last_ff      <= last_in;
      opa_ff       <= opa_in;
      nega_ff      <= nega_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_skip_ff  <= rsp_skip_in;
      rsp_last_ff  <= rsp_last_in;
   end

   ssos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ssos_pkg::SUM_BITS'(prod_ff)),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ssos_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .cmd     (acc_cmd),
      .rd_data (acc_rd)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.row            = rsp_row_ff;
   assign rsp_chan.col            = rsp_col_ff;
   assign rsp_chan.entry          = rsp_entry_ff;
   assign rsp_chan.skipped_points = rsp_skip_ff;
   assign rsp_chan.last_entry     = rsp_last_ff;

   // a request starts the squaring pass
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == ST_SQ_LOAD)
      else $error("request did not start the squaring pass");

   // the final entry of a matrix sits on the diagonal
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_row_ff == rsp_col_ff)
      else $error("last entry off the diagonal");

   // quotients arrive only while the sequencer waits for one
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_PR_WAIT)
      else $error("divider done outside wait state");

   // loading the final entry returns to idle with it pending
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      final_load |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("emit sequence did not end cleanly");

endmodule

`default_nettype wire

[rtl/core/ssos_div.sv]
// ssos_div: shared restoring divider, one quotient bit per cycle,
// gives floor(dividend * 2^FRAC_BITS / divisor) for dividend <= divisor
// depends on ssos_pkg
`default_nettype none

module ssos_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ssos_pkg::SUM_BITS-1:0]      dividend,
   input  logic [ssos_pkg::SUM_BITS-1:0]      divisor,
   output logic                               done,
   output logic [ssos_pkg::Q_BITS-1:0]        quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ssos_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [ssos_pkg::SUM_BITS:0]       rem_ff, rem_in;
   logic [ssos_pkg::Q_BITS-1:0]       quo_ff, quo_in;
   logic [ssos_pkg::SUM_BITS:0]       shifted;
   logic [ssos_pkg::SUM_BITS:0]       div_ext;
   logic                              ge;
   logic                              last_step;

   always_comb begin
      div_ext   = {1'b0, divisor};
      shifted   = (step_ff == '0) ? rem_ff : {rem_ff[ssos_pkg::SUM_BITS-1:0], 1'b0};
      ge        = (shifted >= div_ext);
      last_step = (step_ff == ssos_pkg::STEP_BITS'(ssos_pkg::Q_BITS - 1));
      busy_in   = busy_ff;
      done_in   = busy_ff && last_step;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend};
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - div_ext) : shifted;
         quo_in  = {quo_ff[ssos_pkg::Q_BITS-2:0], ge};
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/ssos_acc.sv]
// ssos_acc: upper-triangle accumulator bank with saturating add,
// one entry addressed per cycle, whole bank cleared on command
// depends on ssos_pkg
`default_nettype none

module ssos_acc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssos_pkg::acc_cmd_type                cmd,
   output logic signed [ssos_pkg::ACC_BITS-1:0] rd_data
);

   logic signed [ssos_pkg::ACC_BITS-1:0] acc_ff [ssos_pkg::TRI_SIZE];
   logic signed [ssos_pkg::ACC_BITS:0]   wide_sum;
   logic signed [ssos_pkg::ACC_BITS-1:0] sat_sum;

   always_comb begin
      rd_data  = acc_ff[cmd.idx];
      wide_sum = {rd_data[ssos_pkg::ACC_BITS-1], rd_data}
               + {cmd.addend[ssos_pkg::ACC_BITS-1], $signed(cmd.addend)};
      if (wide_sum[ssos_pkg::ACC_BITS] != wide_sum[ssos_pkg::ACC_BITS-1]) begin
         sat_sum = wide_sum[ssos_pkg::ACC_BITS] ? ssos_pkg::ACC_LO : ssos_pkg::ACC_HI;
      end else begin
         sat_sum = wide_sum[ssos_pkg::ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int n = 0; n < ssos_pkg::TRI_SIZE; n++) begin
            acc_ff[n] <= '0;
         end
      end else if (cmd.write) begin
         acc_ff[cmd.idx] <= sat_sum;
      end
   end

endmodule

`default_nettype wire

[test/testbench.sv]
// testbench: self-checking bench for spatial_sign_outer_sum_core, with random burst
// traffic on the request side, random stalls on the response side and a matrix predictor
// depends on ssos_pkg, ssos_if and spatial_sign_outer_sum_core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SETTLE_CYCLES = 300;
   localparam int LONG_HOLD     = 2000;
   localparam int RANDOM_POINTS = 245;

   typedef struct packed {
      logic signed [ssos_pkg::COORD_BITS-1:0] coord_0;
      logic signed [ssos_pkg::COORD_BITS-1:0] coord_1;
      logic signed [ssos_pkg::COORD_BITS-1:0] coord_2;
      logic signed [ssos_pkg::COORD_BITS-1:0] coord_3;
      logic                                   last_point;
   } point_type;

   typedef struct packed {
      logic [ssos_pkg::ROW_BITS-1:0]        row;
      logic [ssos_pkg::ROW_BITS-1:0]        col;
      logic signed [ssos_pkg::ENT_BITS-1:0] entry;
      logic [ssos_pkg::SKIP_BITS-1:0]       skipped_points;
      logic                                 last_entry;
   } matrix_entry_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_STRIDE
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssos_req_if req_chan ();
   ssos_rsp_if rsp_chan ();
   ssos_csr_if csr_chan ();

   spatial_sign_outer_sum_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   point_type           pending_points [$];
   matrix_entry_type    expected_entries [$];
   int                  points_queued = 0;
   int                  points_taken = 0;
   int                  mismatch_count = 0;
   int                  holds_asked = 0;
   logic                point_taken = 1'b0;

   // predictor state
   logic [ssos_pkg::CFG_BITS-1:0] model_dims = ssos_pkg::DIMS_RESET;
   longint                        upper_sums [ssos_pkg::TRI_SIZE];
   int                            zero_points = 0;

   function automatic int upper_slot(input int i, input int j);
      int lo;
      int hi;
      int base;
      lo = (i < j) ? i : j;
      hi = (i < j) ? j : i;
      base = 0;
      for (int r = 0; r < lo; r++) base += ssos_pkg::MAX_DIMS - r;
      return base + hi - lo;
   endfunction

   function automatic void fold_point(input point_type p);
      int               raw [4];
      longint unsigned  mag [4];
      bit               neg [4];
      longint unsigned  norm_sq;
      longint unsigned  quo;
      longint           term;
      longint           sum;
      longint           acc_top;
      longint           ent_top;
      int               k;
      int               slot;
      matrix_entry_type e;
      raw[0] = p.coord_0;
      raw[1] = p.coord_1;
      raw[2] = p.coord_2;
      raw[3] = p.coord_3;
      acc_top = (64'sd1 <<< (ssos_pkg::ACC_BITS - 1)) - 1;
      ent_top = (64'sd1 <<< (ssos_pkg::ENT_BITS - 1)) - 1;
      k = (model_dims == 0) ? 1 :
          (model_dims > ssos_pkg::MAX_DIMS) ? ssos_pkg::MAX_DIMS : int'(model_dims);
      norm_sq = 0;
      for (int i = 0; i < k; i++) begin
         neg[i] = raw[i] < 0;
         mag[i] = neg[i] ? longint'(-raw[i]) : longint'(raw[i]);
         norm_sq += mag[i] * mag[i];
      end
      if (norm_sq == 0) begin
         if (zero_points < (1 << ssos_pkg::COUNT_BITS) - 1) zero_points++;
      end else begin
         for (int i = 0; i < k; i++) begin
            for (int j = i; j < k; j++) begin
               quo = ((mag[i] * mag[j]) << ssos_pkg::FRAC_BITS) / norm_sq;
               term = (neg[i] != neg[j]) ? -longint'(quo) : longint'(quo);
               slot = upper_slot(i, j);
               sum = upper_sums[slot] + term;
               if (sum > acc_top) sum = acc_top;
               if (sum < -acc_top - 1) sum = -acc_top - 1;
               upper_sums[slot] = sum;
            end
         end
      end
      if (p.last_point) begin
         for (int i = 0; i < k; i++) begin
            for (int j = 0; j < k; j++) begin
               sum = upper_sums[upper_slot(i, j)];
               if (sum > ent_top) sum = ent_top;
               if (sum < -ent_top - 1) sum = -ent_top - 1;
               e.row = ssos_pkg::ROW_BITS'(i);
               e.col = ssos_pkg::ROW_BITS'(j);
               e.entry = ssos_pkg::ENT_BITS'(sum);
               e.skipped_points = (zero_points > ssos_pkg::SKIP_MAX) ?
                                  ssos_pkg::SKIP_BITS'(ssos_pkg::SKIP_MAX) :
                                  ssos_pkg::SKIP_BITS'(zero_points);
               e.last_entry = (i == k - 1) && (j == k - 1);
               expected_entries.push_back(e);
            end
         end
         foreach (upper_sums[x]) upper_sums[x] = 0;
         zero_points = 0;
      end
   endfunction

   function automatic void check_field(input string field, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // request acceptance and prediction
   always @(posedge clock) begin
      point_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         fold_point('{req_chan.coord_0, req_chan.coord_1, req_chan.coord_2,
                      req_chan.coord_3, req_chan.last_point});
         points_taken++;
      end
   end

   // request driver, bursts with gaps
   always @(negedge clock) begin : drive_points
      point_type nxt;
      int        burst_left;
      int        gap_left;
      if (!reset) begin
         if (req_chan.valid && !point_taken) begin
         end else if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left--;
         end else if (pending_points.size() > 0) begin
            nxt = pending_points.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.coord_0    <= nxt.coord_0;
            req_chan.coord_1    <= nxt.coord_1;
            req_chan.coord_2    <= nxt.coord_2;
            req_chan.coord_3    <= nxt.coord_3;
            req_chan.last_point <= nxt.last_point;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 8);
               case ($urandom_range(0, 7))
                  0, 1:    gap_left = 0;
                  2:       gap_left = $urandom_range(13, 250);
                  default: gap_left = $urandom_range(1, 12);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response stalls, plus the long hold on request
   always @(negedge clock) begin : drive_ready
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      int             holds_served;
      int             tick;
      logic           go;
      tick++;
      if (hold_left > 0) begin
         hold_left--;
         go = 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         go = 1'b0;
      end else begin
         if (mode_left <= 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         case (mode)
            READY_ALWAYS: go = 1'b1;
            STALL_LIGHT:  go = $urandom_range(0, 3) != 0;
            STALL_HEAVY:  go = $urandom_range(0, 3) == 0;
            default:      go = (tick % 5) < 2;
         endcase
      end
      rsp_chan.ready <= go;
   end

   // response checker
   always @(posedge clock) begin : check_entries
      matrix_entry_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_entries.size() == 0) begin
            $error("unexpected entry row %0d col %0d", rsp_chan.row, rsp_chan.col);
            mismatch_count++;
         end else begin
            want = expected_entries.pop_front();
            check_field("row", 64'(want.row), 64'(rsp_chan.row));
            check_field("col", 64'(want.col), 64'(rsp_chan.col));
            check_field("entry", 64'(want.entry), 64'(rsp_chan.entry));
            check_field("skipped_points", 64'(want.skipped_points),
                        64'(rsp_chan.skipped_points));
            check_field("last_entry", 64'(want.last_entry), 64'(rsp_chan.last_entry));
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** spatial_sign_outer_sum_core: FAILED **");
      $finish;
   end

   function automatic void queue_coords(input int c0, input int c1, input int c2,
                                        input int c3, input logic last);
      pending_points.push_back('{ssos_pkg::COORD_BITS'(c0), ssos_pkg::COORD_BITS'(c1),
                                 ssos_pkg::COORD_BITS'(c2), ssos_pkg::COORD_BITS'(c3),
                                 last});
      points_queued++;
   endfunction

   function automatic int random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return int'($signed(ssos_pkg::COORD_BITS'($urandom)));
         4, 5:       return int'($urandom_range(0, 128)) - 64;
         6:          return -(1 << (ssos_pkg::COORD_BITS - 1));
         7:          return (1 << (ssos_pkg::COORD_BITS - 1)) - 1;
         8:          return 0;
         default:    return $urandom_range(0, 1) ? 1 : -1;
      endcase
   endfunction

   task automatic write_dims(input int value);
      @(negedge clock);
      csr_chan.valid       <= 1'b1;
      csr_chan.dims_in_use <= ssos_pkg::CFG_BITS'(value);
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      model_dims = ssos_pkg::CFG_BITS'(value);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // wait until every request is taken, every entry is back and the core is idle
   task automatic settle_idle();
      while (points_taken != points_queued || expected_entries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int  random_points;
      int  set_count;
      int  set_len;
      bit  open_set;
      foreach (upper_sums[x]) upper_sums[x] = 0;
      req_chan.valid       = 1'b0;
      req_chan.coord_0     = '0;
      req_chan.coord_1     = '0;
      req_chan.coord_2     = '0;
      req_chan.coord_3     = '0;
      req_chan.last_point  = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.dims_in_use = ssos_pkg::DIMS_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset width, extremes and a zero point
      queue_coords(32767, 0, 0, 0, 1'b0);
      queue_coords(-32768, -32768, -32768, -32768, 1'b0);
      queue_coords(-32768, 32767, 1, -1, 1'b0);
      queue_coords(0, 0, 0, 0, 1'b0);
      queue_coords(1, -1, 1, -1, 1'b1);
      settle_idle();

      // width zero acts as one, unused coordinates ignored
      write_dims(0);
      queue_coords(-32768, 5, 5, 5, 1'b0);
      queue_coords(0, 7, 7, 7, 1'b0);
      queue_coords(12345, -3, 9, 2, 1'b1);
      settle_idle();

      // width above the maximum
      write_dims(7);
      queue_coords(100, -200, 300, -400, 1'b0);
      queue_coords(-1, 0, 0, 0, 1'b1);
      settle_idle();

      write_dims(2);
      queue_coords(3, 4, 32767, -32768, 1'b0);
      queue_coords(-3, 4, 0, 0, 1'b1);
      settle_idle();

      // set made of a single zero point
      write_dims(3);
      queue_coords(0, 0, 0, 0, 1'b1);
      settle_idle();

      // width change inside a set, then check the clear
      write_dims(4);
      queue_coords(1000, 2000, 3000, 4000, 1'b0);
      settle_idle();
      write_dims(2);
      queue_coords(-5, 7, 0, 0, 1'b1);
      settle_idle();
      write_dims(4);
      queue_coords(1, 1, 1, 1, 1'b1);

      // long response hold while requests keep coming
      holds_asked++;
      queue_coords(-20000, 15000, -7, 32767, 1'b1);
      queue_coords(9, -9, 9, -9, 1'b0);
      queue_coords(-32768, 0, 32767, 1, 1'b1);
      queue_coords(2, 3, 5, 7, 1'b1);
      settle_idle();

      random_points = 0;
      while (random_points < RANDOM_POINTS) begin
         write_dims($urandom_range(0, 7));
         set_count = $urandom_range(1, 4);
         for (int s = 0; s < set_count; s++) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20)
                                                 : $urandom_range(1, 5);
            open_set = (s == set_count - 1) && ($urandom_range(0, 7) == 0);
            for (int n = 0; n < set_len; n++) begin
               if ($urandom_range(0, 11) == 0)
                  queue_coords(0, 0, 0, 0, (n == set_len - 1) && !open_set);
               else
                  queue_coords(random_coord(), random_coord(), random_coord(),
                               random_coord(), (n == set_len - 1) && !open_set);
            end
            random_points += set_len;
         end
         settle_idle();
      end

      if (mismatch_count == 0 && expected_entries.size() == 0) begin
         $display("** spatial_sign_outer_sum_core: PASSED **");
      end else begin
         $display("** spatial_sign_outer_sum_core: FAILED **");
      end
      $finish;
   end

endmodule

[spatial_sign_outer_sum_core.f]
rtl/core/ssos_pkg.sv
rtl/core/ssos_if.sv
rtl/core/ssos_div.sv
rtl/core/ssos_acc.sv
rtl/core/spatial_sign_outer_sum_core.sv
test/testbench.sv
